// File: rtl/core/klk_pkg.sv
package klk_pkg;

  // Input item kinds.
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Key codes: the highest digit code and the codes that are not digits.
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_CLEAR     = 4'd10;
  localparam logic [3:0] KEY_SUBMIT    = 4'd11;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SECRET_CODE     = 2'd0;
  localparam logic [1:0] CFG_MAX_ATTEMPTS    = 2'd1;
  localparam logic [1:0] CFG_LOCKOUT_SECONDS = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] SECRET_CODE_RST     = 16'h1111;
  localparam logic [2:0]  MAX_ATTEMPTS_RST    = 3'd3;
  localparam logic [7:0]  LOCKOUT_SECONDS_RST = 8'd10;

  typedef enum logic [2:0] {
    EV_IGNORED   = 3'd0,
    EV_DIGIT     = 3'd1,
    EV_REMOVED   = 3'd2,
    EV_GRANTED   = 3'd3,
    EV_WRONG     = 3'd4,
    EV_LOCKED    = 3'd5,
    EV_LOCK_TICK = 3'd6,
    EV_UNLOCKED  = 3'd7
  } event_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_DIGIT,
    CMD_CLEAR,
    CMD_SUBMIT,
    CMD_TICK
  } cmd_e;

  typedef struct packed {
    logic       kind;
    logic [3:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [2:0] entered_count;
    logic [2:0] attempts_left;
    logic [7:0] lock_seconds_left;
    logic       buzzer_on;
    logic       access_granted;
  } res_item_t;

  // Classified command passed from the front end to the execution side.
  typedef struct packed {
    cmd_e       op;
    logic [3:0] digit;
  } cmd_t;

  typedef struct packed {
    logic [15:0] secret_code;
    logic [2:0]  max_attempts;
    logic [7:0]  lockout_seconds;
  } cfg_t;

endpackage

// File: rtl/core/keypad_combination_lock.sv
// Keypad combination lock with lockout. Each input item is a decoded key
// (digits 0 to 9, clear, submit) or a one-second tick, and each one yields
// exactly one result item that reports what happened together with the
// digit count, the attempts left, the lockout time left, the buzzer and the
// grant flag. The block takes one item per clock cycle while the result
// channel does not stall; a result passes a classification register, a
// two-entry command queue and the result register of the execution side.
// All state is updated by a single execution step per popped command.
// Configuration is written through a simple write port only while the
// block is idle, a rule the user must keep since the block itself does not
// enforce it; there is no clearing pass after reset.

module keypad_combination_lock import klk_pkg::*; #(
  parameter int CODE_DIGITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output res_item_t   out_item_o
);

  // The configuration registers are held here and fed to the execution side.
  cfg_t cfg_q, cfg_d;

  // Connections between the front end, the queue and the execution side.
  logic fe_push;
  cmd_t fe_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic be_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SECRET_CODE:     cfg_d.secret_code     = cfg_wdata_i;
        CFG_MAX_ATTEMPTS:    cfg_d.max_attempts    = cfg_wdata_i[2:0];
        CFG_LOCKOUT_SECONDS: cfg_d.lockout_seconds = cfg_wdata_i[7:0];
        default: begin
          // Writes to an unused index are dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.secret_code     <= SECRET_CODE_RST;
      cfg_q.max_attempts    <= MAX_ATTEMPTS_RST;
      cfg_q.lockout_seconds <= LOCKOUT_SECONDS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end accepts each item and sorts it into a command.
  klk_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (fe_push),
    .cmd_o      (fe_cmd),
    .full_i     (q_full)
  );

  // A short queue lets the two sides stall independently.
  klk_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fe_push),
    .push_data_i (fe_cmd),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_cmd),
    .pop_i       (be_pop)
  );

  // The execution side owns the lock state and the result register.
  klk_back #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (be_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: rtl/core/klk_front.sv
module klk_front import klk_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     push_o,
  output cmd_t     cmd_o,
  input  logic     full_i
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic take;

  // The stage holds one classified item and hands it on when the queue has room.
  assign push_o     = valid_q && !full_i;
  assign in_stall_o = valid_q && full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign cmd_o      = cmd_q;

  always_comb begin
    cmd_d.digit = in_item_i.key_code;
    if (in_item_i.kind == KIND_TICK) begin
      cmd_d.op = CMD_TICK;
    end else if (in_item_i.key_code inside {[4'd0:KEY_DIGIT_MAX]}) begin
      cmd_d.op = CMD_DIGIT;
    end else if (in_item_i.key_code == KEY_CLEAR) begin
      cmd_d.op = CMD_CLEAR;
    end else if (in_item_i.key_code == KEY_SUBMIT) begin
      cmd_d.op = CMD_SUBMIT;
    end else begin
      cmd_d.op = CMD_NONE;
    end
    valid_d = take || (valid_q && !push_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// File: rtl/core/klk_fifo.sv
module klk_fifo import klk_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t data_o,
  input  logic pop_i
);

  localparam int Depth = 2;

  cmd_t       mem_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'(Depth));
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/klk_back.sv
module klk_back import klk_pkg::*; #(
  parameter int CODE_DIGITS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output res_item_t out_item_o
);

  localparam int CntW = $clog2(CODE_DIGITS + 1);
  localparam int IdxW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int PadW = 4 * ((CODE_DIGITS > 4) ? CODE_DIGITS : 4);

  logic [3:0]      entry_q [CODE_DIGITS];
  logic [CntW-1:0] count_q, count_d;
  logic [2:0]      wrong_q, wrong_d;
  logic            locked_q, locked_d;
  logic [7:0]      rem_q, rem_d;
  logic            out_valid_q;
  res_item_t       out_q, res_d;

  logic [PadW-1:0] secret_pad;
  logic            match;
  logic            write_digit;
  logic [2:0]      wrong_inc;
  event_e          ev;

  assign cmd_pop_o   = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Code positions beyond the stored four compare against digit zero.
  assign secret_pad = PadW'(cfg_i.secret_code);

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (entry_q[i] != secret_pad[4*i +: 4]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    count_d     = count_q;
    wrong_d     = wrong_q;
    locked_d    = locked_q;
    rem_d       = rem_q;
    write_digit = 1'b0;
    wrong_inc   = wrong_q + 3'd1;
    ev          = EV_IGNORED;
    case (cmd_i.op)
      CMD_TICK: begin
        if (locked_q) begin
          if (rem_q <= 8'd1) begin
            rem_d    = 8'd0;
            locked_d = 1'b0;
            wrong_d  = 3'd0;
            ev       = EV_UNLOCKED;
          end else begin
            rem_d = rem_q - 8'd1;
            ev    = EV_LOCK_TICK;
          end
        end
      end
      CMD_DIGIT: begin
        if (!locked_q && count_q < CntW'(CODE_DIGITS)) begin
          write_digit = 1'b1;
          count_d     = count_q + CntW'(1);
          ev          = EV_DIGIT;
        end
      end
      CMD_CLEAR: begin
        if (!locked_q && count_q != '0) begin
          count_d = count_q - CntW'(1);
          ev      = EV_REMOVED;
        end
      end
      CMD_SUBMIT: begin
        if (!locked_q && count_q == CntW'(CODE_DIGITS)) begin
          count_d = '0;
          if (match) begin
            wrong_d = 3'd0;
            ev      = EV_GRANTED;
          end else begin
            wrong_d = wrong_inc;
            // The count wraps to zero at eight, which also engages the lock.
            if (wrong_inc >= cfg_i.max_attempts || wrong_inc == 3'd0) begin
              locked_d = 1'b1;
              rem_d    = cfg_i.lockout_seconds;
              ev       = EV_LOCKED;
            end else begin
              ev = EV_WRONG;
            end
          end
        end
      end
      default: begin
      end
    endcase

    res_d.event_res     = ev;
    res_d.entered_count = 3'(count_d);
    if (locked_d || wrong_d >= cfg_i.max_attempts) begin
      res_d.attempts_left = 3'd0;
    end else begin
      res_d.attempts_left = cfg_i.max_attempts - wrong_d;
    end
    res_d.lock_seconds_left = locked_d ? rem_d : 8'd0;
    res_d.buzzer_on         = locked_d || (ev == EV_WRONG);
    res_d.access_granted    = (ev == EV_GRANTED);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      wrong_q     <= 3'd0;
      locked_q    <= 1'b0;
      rem_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        count_q  <= count_d;
        wrong_q  <= wrong_d;
        locked_q <= locked_d;
        rem_q    <= rem_d;
      end
      if (cmd_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      out_q <= res_d;
    end
    if (cmd_pop_o && write_digit) begin
      entry_q[count_q[IdxW-1:0]] <= cmd_i.digit;
    end
  end

endmodule

// File: rtl/core/klk_checker.sv
module klk_checker import klk_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input res_item_t out_item_i
);

  // A result that is held back stays in place unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_item_i))
    else $error("stalled result changed");

  // Access is granted on a grant event and on nothing else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_item_i.access_granted == (out_item_i.event_res == EV_GRANTED)))
    else $error("grant flag does not follow the event");

  // Engaging the lock empties the buffer, leaves no attempts and sounds the buzzer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.event_res == EV_LOCKED |->
      out_item_i.buzzer_on && out_item_i.attempts_left == 3'd0 &&
      out_item_i.entered_count == 3'd0)
    else $error("lock event with inconsistent status");

  // A wrong entry sounds the buzzer while attempts remain and no lockout runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.event_res == EV_WRONG |->
      out_item_i.buzzer_on && out_item_i.attempts_left != 3'd0 &&
      out_item_i.lock_seconds_left == 8'd0)
    else $error("wrong entry with inconsistent status");

  // A countdown tick leaves some lockout time and keeps the buzzer on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.event_res == EV_LOCK_TICK |->
      out_item_i.buzzer_on && out_item_i.lock_seconds_left != 8'd0)
    else $error("lockout tick with no time left");

endmodule

bind keypad_combination_lock klk_checker u_klk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_i  (out_item_o)
);
